// File: src/dtu_pkg.sv
// dtu_pkg: shared types, constants and helpers for the decimal text converter.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package dtu_pkg;

  // Result width modes; the unused code behaves as the 64-bit mode
  localparam logic [1:0] MODE_16 = 2'd0;
  localparam logic [1:0] MODE_32 = 2'd1;
  localparam logic [1:0] MODE_64 = 2'd2;
  localparam logic [1:0] MODE_RESET = MODE_32;

  // ASCII digit bounds
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  // Character counter saturates here
  localparam logic [4:0] COUNT_SAT = 5'd31;

  // Default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified character, as it travels from front to back
  typedef struct packed {
    logic       is_digit;
    logic [3:0] digit;
    logic       no_char;
    logic       last_char;
  } item_t;

  // Longest accepted string for a mode
  function automatic logic [4:0] width_len(input logic [1:0] mode);
    logic [4:0] len;
    case (mode)
      MODE_16: len = 5'd5;
      MODE_32: len = 5'd10;
      default: len = 5'd20;
    endcase
    return len;
  endfunction

endpackage

// File: src/dtu_front.sv
// dtu_front: classifies each incoming character beat into a queue item.
// Depends on dtu_pkg.
`timescale 1ns / 1ps

module dtu_front (
  input  logic [7:0]     char_code,
  input  logic           no_char,
  input  logic           last_char,
  output dtu_pkg::item_t item
);

  logic       is_digit;
  logic [7:0] offset;

  // Digit test and digit value
  assign is_digit = (char_code >= dtu_pkg::CHAR_0) && (char_code <= dtu_pkg::CHAR_9);
  assign offset   = char_code - dtu_pkg::CHAR_0;

  always_comb begin
    item.is_digit  = is_digit;
    item.digit     = offset[3:0];
    item.no_char   = no_char;
    item.last_char = last_char;
  end

endmodule

// File: src/dtu_queue.sv
// dtu_queue: short FIFO of classified items between front and back.
// Depends on dtu_pkg.
`timescale 1ns / 1ps

module dtu_queue #(
  parameter int DEPTH = dtu_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dtu_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output dtu_pkg::item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  dtu_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: src/dtu_back.sv
// dtu_back: folds digits into the accumulator, checks range and length,
// and holds the result beat until taken. Depends on dtu_pkg.
`timescale 1ns / 1ps

module dtu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [1:0]     mode,
  input  logic           q_valid,
  input  dtu_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [63:0]    out_tdata,
  output logic           out_tuser
);

  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        fail_r, fail_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r;
  logic        out_ok_r;

  logic [67:0] prod;
  logic        ovf;
  logic        emit;
  logic        ok;
  logic        in_range;

  // acc * 10 + digit, wide enough that it never wraps
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {64'b0, q_item.digit};

  // Fold would exceed the largest value of the mode
  always_comb begin
    case (mode)
      dtu_pkg::MODE_16: ovf = |prod[67:16];
      dtu_pkg::MODE_32: ovf = |prod[67:32];
      default:          ovf = |prod[67:64];
    endcase
  end

  assign emit  = q_item.no_char || q_item.last_char;
  assign q_pop = q_valid && (!emit || !out_valid_r || out_tready);

  // Character step on the popped item
  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    fail_nxt = fail_r;
    if (!q_item.no_char) begin
      if (cnt_r != dtu_pkg::COUNT_SAT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (!fail_r) begin
        if (q_item.is_digit && !ovf) begin
          acc_nxt = prod[63:0];
        end else begin
          fail_nxt = 1'b1;
        end
      end
    end
  end

  // End-of-string checks against the mode in force
  always_comb begin
    case (mode)
      dtu_pkg::MODE_16: in_range = ~|acc_nxt[63:16];
      dtu_pkg::MODE_32: in_range = ~|acc_nxt[63:32];
      default:          in_range = 1'b1;
    endcase
  end

  assign ok = !fail_nxt && (cnt_nxt != '0) && (cnt_nxt <= dtu_pkg::width_len(mode)) &&
              in_range;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // String state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        if (emit) begin
          acc_r  <= '0;
          cnt_r  <= '0;
          fail_r <= 1'b0;
        end else begin
          acc_r  <= acc_nxt;
          cnt_r  <= cnt_nxt;
          fail_r <= fail_nxt;
        end
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_value_r <= ok ? acc_nxt : 64'd0;
      out_ok_r    <= ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_ok_r;

  // A string end leaves the state cleared
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && emit) |=> (acc_r == 64'd0 && cnt_r == 5'd0 && !fail_r))
    else $error("string state not cleared after end");

  // A failed parse reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_value_r == 64'd0))
    else $error("failed parse with nonzero value");

  // Accumulator is frozen once the string has failed
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (fail_r && !(q_pop && emit)) |=> $stable(acc_r))
    else $error("accumulator moved after failure");

  // A waiting result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(q_pop && emit))
    else $error("result overwritten while stalled");

endmodule

// File: src/decimal_text_to_unsigned_core.sv
// decimal_text_to_unsigned_core: top level of the decimal text converter.
// Depends on dtu_pkg, dtu_front, dtu_queue and dtu_back.
`timescale 1ns / 1ps
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------
//  in_     | slave     | tdata: char_code; tuser: no_char; tlast: last_char
//  out_    | master    | tdata: parsed_value; tuser: parse_ok
//  cfg_    | slave     | data: result_width_mode
//
//  One character beat per cycle is taken while the queue has room; the beat that
//  ends a string passes the queue slot, then the fold stage's result register.
//  The queue between classifier and fold stage absorbs output stalls;
//  in_tready drops only once the queue is full. cfg_ready is always high.
//  Reset (synchronous, rst_n low) empties the queue, clears the string
//  state and sets the 32-bit mode.

module decimal_text_to_unsigned_core #(
  parameter int QUEUE_DEPTH = dtu_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tuser,   // [0] no_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] parsed_value
  output logic        out_tuser,  // [0] parse_ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic [1:0]     mode_r;
  dtu_pkg::item_t front_item;
  dtu_pkg::item_t head_item;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;
  logic           push;

  // Mode register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dtu_pkg::MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  // Classifier
  dtu_front u_front (
    .char_code (in_tdata),
    .no_char   (in_tuser),
    .last_char (in_tlast),
    .item      (front_item)
  );

  // Queue between front and back
  dtu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Fold stage and result register
  dtu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mode       (mode_r),
    .q_valid    (q_not_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for decimal_text_to_unsigned_core.
// Depends on dtu_pkg (mode codes, digit bounds, counter limit) and the core RTL.

module testbench;

  localparam int SETTLE_CYCLES = 8;      // drain time for beats that cause no result
  localparam int CYCLE_LIMIT   = 100000;
  localparam int IDLE_PCT      = 37;
  localparam int RANDOM_BEATS  = 660;
  localparam int PHASE_BEATS   = 90;
  localparam int CALM_BEATS    = 150;

  typedef struct packed {
    logic [63:0] value;
    logic        ok;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        in_tuser = 1'b0; // [0] no_char
  logic        in_tlast = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // [63:0] parsed_value
  logic        out_tuser;       // [0] parse_ok
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;

  // Shadow of the converter state
  logic [1:0]  width_mode = dtu_pkg::MODE_RESET;
  logic [63:0] acc = '0;
  logic [4:0]  char_cnt = '0;
  logic        failed = 1'b0;

  parse_result_t expected_results[$];
  logic [7:0]    text[$];
  int            errors = 0;
  int            beats_sent = 0;
  bit            calm = 1'b0;

  decimal_text_to_unsigned_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mode_max(input logic [1:0] m);
    case (m)
      dtu_pkg::MODE_16: return 64'hFFFF;
      dtu_pkg::MODE_32: return 64'hFFFF_FFFF;
      default: return '1;
    endcase
  endfunction

  function automatic int mode_len(input logic [1:0] m);
    case (m)
      dtu_pkg::MODE_16: return 5;
      dtu_pkg::MODE_32: return 10;
      default: return 20;
    endcase
  endfunction

  // Fold one accepted beat into the shadow state; queue a result at string end
  task automatic fold_beat(input logic [7:0] ch, input logic none, input logic last);
    logic [63:0]   d;
    logic          ok;
    parse_result_t r;
    if (!none) begin
      if (char_cnt != dtu_pkg::COUNT_SAT) char_cnt = char_cnt + 5'd1;
      if (!failed) begin
        if (ch >= dtu_pkg::CHAR_0 && ch <= dtu_pkg::CHAR_9) begin
          d = 64'(ch - dtu_pkg::CHAR_0);
          // overflow test ahead of the multiply-add
          if (acc > (mode_max(width_mode) - d) / 64'd10) failed = 1'b1;
          else acc = acc * 64'd10 + d;
        end else begin
          failed = 1'b1;
        end
      end
    end
    if (none || last) begin
      ok = !failed && char_cnt != 0 && int'(char_cnt) <= mode_len(width_mode) &&
           acc <= mode_max(width_mode);
      r.value = ok ? acc : 64'd0;
      r.ok = ok;
      expected_results.insert(expected_results.size(), r);
      acc = '0;
      char_cnt = '0;
      failed = 1'b0;
    end
  endtask

  // One input beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [7:0] ch, input logic none, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= none;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    fold_beat(ch, none, last);
    beats_sent++;
  endtask

  // Stop sending, wait for every pending result, then let the pipe empty
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_mode = m;
  endtask

  // Send the text buffer as one string; optionally switch mode before char switch_at
  task automatic send_text(input bit by_none, input logic none_last, input int switch_at,
                           input logic [1:0] switch_mode);
    for (int i = 0; i < text.size(); i++) begin
      if (i == switch_at) begin
        drain_results();
        write_width_mode(switch_mode);
      end
      send_beat(text[i], 1'b0, !by_none && i == text.size() - 1);
    end
    if (switch_at == text.size()) begin
      drain_results();
      write_width_mode(switch_mode);
    end
    if (by_none) send_beat(8'($urandom_range(255)), 1'b1, none_last);
    text.delete();
  endtask

  function automatic void add_decimal(input logic [63:0] v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(dtu_pkg::CHAR_0 + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digits[i]) text.insert(text.size(), digits[i]);
  endfunction

  function automatic void add_zeros(input int n);
    repeat (n) text.insert(text.size(), dtu_pkg::CHAR_0);
  endfunction

  function automatic void add_digits(input int n);
    repeat (n) text.insert(text.size(), dtu_pkg::CHAR_0 + 8'($urandom_range(9)));
  endfunction

  function automatic logic [7:0] pick_non_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c >= dtu_pkg::CHAR_0 && c <= dtu_pkg::CHAR_9);
    return c;
  endfunction

  // Digit bounds, odd codes, all-ones / all-zeros characters and a short number
  task automatic test_basic_chars();
    send_beat(dtu_pkg::CHAR_0, 1'b0, 1'b1);
    send_beat(dtu_pkg::CHAR_9, 1'b0, 1'b1);
    send_beat(dtu_pkg::CHAR_0 - 8'd1, 1'b0, 1'b1);
    send_beat(dtu_pkg::CHAR_9 + 8'd1, 1'b0, 1'b1);
    send_beat(8'hFF, 1'b0, 1'b1);
    send_beat(8'h00, 1'b0, 1'b1);
    add_decimal(64'd123);
    send_text(1'b0, 1'b0, -1, dtu_pkg::MODE_32);
  endtask

  // Empty strings and strings closed by a beat without a character
  task automatic test_string_ends();
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'hFF, 1'b1, 1'b0);
    send_beat(dtu_pkg::CHAR_0 + 8'd8, 1'b0, 1'b0);
    send_beat(8'hA5, 1'b1, 1'b1);
    send_beat(dtu_pkg::CHAR_0 + 8'd8, 1'b0, 1'b0);
    send_beat(dtu_pkg::CHAR_9, 1'b1, 1'b0);
  endtask

  // Mode switches inside a string, and the unused mode code
  task automatic test_mode_change();
    drain_results();
    write_width_mode(dtu_pkg::MODE_64);
    add_decimal(64'd70000);
    send_text(1'b0, 1'b0, 3, dtu_pkg::MODE_16);   // fold fails under the narrow mode
    drain_results();
    write_width_mode(dtu_pkg::MODE_32);
    add_decimal(64'd70000);
    send_text(1'b1, 1'b1, 5, dtu_pkg::MODE_16);   // value out of range at the end check
    drain_results();
    write_width_mode(2'd3);
    add_decimal(64'd65536);
    send_text(1'b0, 1'b0, -1, dtu_pkg::MODE_64);
  endtask

  task automatic send_random_string();
    int          pick;
    int          sw_at;
    bit          by_none;
    logic [63:0] v;
    pick = $urandom_range(99);
    sw_at = -1;
    by_none = ($urandom_range(9) == 0);
    if (pick < 45) begin
      // well-formed number, mostly in range
      v = {$urandom, $urandom} & mode_max(width_mode);
      v = v >> $urandom_range(63);
      if ($urandom_range(3) == 0) add_zeros($urandom_range(1, 2));
      add_decimal(v);
      if ($urandom_range(29) == 0) sw_at = $urandom_range(text.size());
    end else if (pick < 55) begin
      // values and lengths at the limits of the mode
      case ($urandom_range(4))
        0: add_decimal(mode_max(width_mode));
        1: begin
          add_decimal(mode_max(width_mode));
          text[text.size() - 1] = text[text.size() - 1] + 8'd1;  // maxima end in 5
        end
        2: begin
          text.insert(text.size(), dtu_pkg::CHAR_0);
          add_decimal(mode_max(width_mode));
        end
        3: add_zeros(mode_len(width_mode));
        default: add_zeros(mode_len(width_mode) + 1);
      endcase
    end else if (pick < 65) begin
      add_digits($urandom_range(1, mode_len(width_mode)));
      text[$urandom_range(text.size() - 1)] = pick_non_digit();
    end else if (pick < 70) begin
      add_digits($urandom_range(21, 40));       // exceeds every length limit, may saturate the counter
    end else if (pick < 78) begin
      add_digits($urandom_range(1, 22));
    end else if (pick < 84) begin
      by_none = 1'b1;                           // empty string
    end else begin
      // noise: raw beats with random flags
      repeat ($urandom_range(1, 4))
        send_beat(8'($urandom_range(255)), $urandom_range(3) == 0, 1'($urandom_range(1)));
      return;
    end
    send_text(by_none, 1'($urandom_range(1)), sw_at, 2'($urandom_range(3)));
  endtask

  task automatic test_random_strings();
    int stop_at;
    int calm_until;
    int next_phase;
    stop_at = beats_sent + RANDOM_BEATS;
    calm_until = beats_sent + CALM_BEATS;
    next_phase = beats_sent + PHASE_BEATS;
    while (beats_sent < stop_at) begin
      calm = (beats_sent < calm_until);
      if (beats_sent >= next_phase) begin
        drain_results();
        write_width_mode(2'($urandom_range(3)));
        next_phase = beats_sent + PHASE_BEATS;
      end
      send_random_string();
    end
    calm = 1'b0;
  endtask

  // Result checker and output stall generator
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected: actual value %h ok %b",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: parsed_value mismatch: expected %h actual %h",
                   $time, want.value, out_tdata);
          errors++;
        end
        if (out_tuser !== want.ok) begin
          $display("%0t: parse_ok mismatch: expected %b actual %b",
                   $time, want.ok, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL decimal_text_to_unsigned_core");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_chars();
    test_string_ends();
    test_mode_change();
    test_random_strings();
    drain_results();
    if (errors == 0) begin
      $display("PASS decimal_text_to_unsigned_core");
    end else begin
      $display("FAIL decimal_text_to_unsigned_core");
    end
    $finish;
  end

endmodule
